// ===== hdl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: command and status
// codes and the control group sent from the top level to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-cycle action broadcast along the chain.
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds one entry, keeps it, takes the new
// entry, or takes its neighbor's entry as the chain shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int PRIO_BITS  = 8,
	parameter int VALUE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spq_pkg::spq_ctrl_t    ctrl,
	input  wire logic [PRIO_BITS-1:0]  new_prio,
	input  wire logic [VALUE_BITS-1:0] new_val,
	input  wire logic                  left_vld,
	input  wire logic [PRIO_BITS-1:0]  left_prio,
	input  wire logic [VALUE_BITS-1:0] left_val,
	input  wire logic                  left_ins,
	input  wire logic                  right_vld,
	input  wire logic [PRIO_BITS-1:0]  right_prio,
	input  wire logic [VALUE_BITS-1:0] right_val,
	output logic                       vld,
	output logic [PRIO_BITS-1:0]       prio,
	output logic [VALUE_BITS-1:0]      val,
	output logic                       ins
);

	logic                  vld_q;
	logic [PRIO_BITS-1:0]  prio_q;
	logic [VALUE_BITS-1:0] val_q;

	// Displaced by the new entry: empty, or strictly larger priority.
	assign ins  = !vld_q || (prio_q > new_prio);
	assign vld  = vld_q;
	assign prio = prio_q;
	assign val  = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.deq) begin
			vld_q <= right_vld;
		end else if (ctrl.enq && ins) begin
			vld_q <= left_ins ? left_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			prio_q <= right_prio;
			val_q  <= right_val;
		end else if (ctrl.enq && ins) begin
			// shift back behind the left neighbor, or take the new entry
			if (left_ins) begin
				prio_q <= left_prio;
				val_q  <= left_val;
			end else begin
				prio_q <= new_prio;
				val_q  <= new_val;
			end
		end
	end

endmodule : spq_cell
`default_nettype wire

// ===== hdl/sorted_priority_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Minimum priority queue of DEPTH entries kept sorted in a chain of cells.
// Equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   command, entry_priority, entry_value
//  out      out_valid / out_ready out_priority, out_value, status, occupancy
//
//  One request per cycle while in_ready is high; its result appears in the
//  output register on the next cycle. The cell chain updates all slots in parallel.
//  Reset empties the queue (cell valid bits and count cleared).
//  in_ready is low only while a result waits and out_ready is low.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
	parameter int DEPTH      = 16,
	parameter int PRIO_BITS  = 8,
	parameter int VALUE_BITS = 16,
	localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  command,
	input  wire logic [PRIO_BITS-1:0]  entry_priority,
	input  wire logic [VALUE_BITS-1:0] entry_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PRIO_BITS-1:0]       out_priority,
	output logic [VALUE_BITS-1:0]      out_value,
	output logic [1:0]                 status,
	output logic [CNT_BITS-1:0]        occupancy
);

	logic                  cell_vld  [DEPTH];
	logic [PRIO_BITS-1:0]  cell_prio [DEPTH];
	logic [VALUE_BITS-1:0] cell_val  [DEPTH];
	logic                  cell_ins  [DEPTH];
	logic [DEPTH-1:0]      vld_vec;

	logic                  in_fire;
	logic                  full;
	logic                  empty;
	logic                  is_deq;
	spq_pkg::spq_ctrl_t    ctrl;
	spq_pkg::status_t      status_d;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   count_d;

	logic                  out_valid_q;
	logic [PRIO_BITS-1:0]  out_prio_q;
	logic [VALUE_BITS-1:0] out_val_q;
	spq_pkg::status_t      status_q;
	logic [CNT_BITS-1:0]   occ_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign full     = cell_vld[DEPTH-1];
	assign empty    = !cell_vld[0];
	assign is_deq   = (command == spq_pkg::CMD_DEQ);

	always_comb begin
		ctrl.enq = in_fire && !is_deq && !full;
		ctrl.deq = in_fire && is_deq && !empty;
		count_d  = count_q;
		status_d = spq_pkg::ST_OK;
		if (ctrl.enq) begin
			count_d = count_q + CNT_BITS'(1);
		end else if (ctrl.deq) begin
			count_d = count_q - CNT_BITS'(1);
		end
		if (is_deq && empty) begin
			status_d = spq_pkg::ST_EMPTY;
		end else if (!is_deq && full) begin
			status_d = spq_pkg::ST_FULL;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  l_vld;
		logic [PRIO_BITS-1:0]  l_prio;
		logic [VALUE_BITS-1:0] l_val;
		logic                  l_ins;
		logic                  r_vld;
		logic [PRIO_BITS-1:0]  r_prio;
		logic [VALUE_BITS-1:0] r_val;

		if (i == 0) begin : g_head
			assign l_vld  = 1'b0;
			assign l_prio = '0;
			assign l_val  = '0;
			assign l_ins  = 1'b0;
		end else begin : g_body
			assign l_vld  = cell_vld[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_val  = cell_val[i-1];
			assign l_ins  = cell_ins[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_vld  = 1'b0;
			assign r_prio = '0;
			assign r_val  = '0;
		end else begin : g_next
			assign r_vld  = cell_vld[i+1];
			assign r_prio = cell_prio[i+1];
			assign r_val  = cell_val[i+1];
		end

		spq_cell #(
			.PRIO_BITS  (PRIO_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_prio   (entry_priority),
			.new_val    (entry_value),
			.left_vld   (l_vld),
			.left_prio  (l_prio),
			.left_val   (l_val),
			.left_ins   (l_ins),
			.right_vld  (r_vld),
			.right_prio (r_prio),
			.right_val  (r_val),
			.vld        (cell_vld[i]),
			.prio       (cell_prio[i]),
			.val        (cell_val[i]),
			.ins        (cell_ins[i])
		);

		assign vld_vec[i] = cell_vld[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_prio_q <= ctrl.deq ? cell_prio[0] : '0;
			out_val_q  <= ctrl.deq ? cell_val[0] : '0;
			status_q   <= status_d;
			occ_q      <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_priority = out_prio_q;
	assign out_value    = out_val_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_BITS'($countones(vld_vec)))
		else $error("count differs from number of valid cells");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec + 1'b1) & vld_vec) == '0)
		else $error("valid cells are not packed at the head");

	for (genvar k = 1; k < DEPTH; k++) begin : g_chk_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			cell_vld[k] |-> (cell_prio[k-1] <= cell_prio[k]))
			else $error("chain is out of priority order");
	end

	a_deq_front: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.deq |=> (out_priority == $past(cell_prio[0])) &&
			(status == spq_pkg::ST_OK))
		else $error("dequeue did not return the front entry");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_deq && full) |=> $stable(vld_vec) &&
			(status == spq_pkg::ST_FULL))
		else $error("enqueue on full queue changed the store");
`endif

endmodule : sorted_priority_queue_unit
`default_nettype wire

// ===== test/sorted_priority_queue_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Self-checking bench for the sorted priority queue. A mirror of the queue
// contents, kept as a sorted list, predicts the result of every accepted
// request. A monitor compares each accepted result with the oldest
// prediction. Requests arrive in random bursts while the result side
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;

	localparam int DEPTH        = 16;
	localparam int PRIO_BITS    = 8;
	localparam int VALUE_BITS   = 16;
	localparam int CNT_BITS     = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1425;
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_LIMIT   = 1000;

	typedef struct packed {
		logic [PRIO_BITS-1:0]  prio;
		logic [VALUE_BITS-1:0] value;
	} slot_t;

	typedef struct packed {
		logic [PRIO_BITS-1:0]  prio;
		logic [VALUE_BITS-1:0] value;
		spq_pkg::status_t      st;
		logic [CNT_BITS-1:0]   occ;
	} outcome_t;

	class prio_queue_mirror;
		slot_t       held[$];
		outcome_t    pending_results[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void report(string what, outcome_t want, logic [PRIO_BITS-1:0] p,
				logic [VALUE_BITS-1:0] v, logic [1:0] st, logic [CNT_BITS-1:0] occ);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected prio %0d value %0d status %0d count %0d,",
					$time, what, want.prio, want.value, want.st, want.occ);
				$display("    got prio %0d value %0d status %0d count %0d",
					p, v, st, occ);
			end
		endfunction

		// Apply one accepted request to the mirror and queue its result.
		function void note_request(logic cmd, logic [PRIO_BITS-1:0] p,
				logic [VALUE_BITS-1:0] v);
			outcome_t want;
			slot_t    s;
			int       pos;
			want = '0;
			want.st = spq_pkg::ST_OK;
			if (cmd == spq_pkg::CMD_ENQ) begin
				if (held.size() >= DEPTH) begin
					want.st = spq_pkg::ST_FULL;
				end else begin
					// insert behind every entry of lower or equal priority
					pos = held.size();
					while (pos > 0 && held[pos-1].prio > p)
						pos--;
					s.prio = p;
					s.value = v;
					held.insert(pos, s);
				end
			end else begin
				if (held.size() == 0) begin
					want.st = spq_pkg::ST_EMPTY;
				end else begin
					s = held.pop_front();
					want.prio = s.prio;
					want.value = s.value;
				end
			end
			want.occ = CNT_BITS'(held.size());
			pending_results.push_back(want);
		endfunction

		function void check_result(logic [PRIO_BITS-1:0] p, logic [VALUE_BITS-1:0] v,
				logic [1:0] st, logic [CNT_BITS-1:0] occ);
			outcome_t want;
			if (pending_results.size() == 0) begin
				want = '0;
				report("unexpected result", want, p, v, st, occ);
			end else begin
				want = pending_results.pop_front();
				if (p !== want.prio || v !== want.value || st !== want.st || occ !== want.occ)
					report("mismatch", want, p, v, st, occ);
			end
		endfunction

		function void close_out();
			if (pending_results.size() != 0) begin
				mismatches += pending_results.size();
				$display("%0d results never arrived", pending_results.size());
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = spq_pkg::CMD_ENQ;
	logic [PRIO_BITS-1:0]  entry_priority = '0;
	logic [VALUE_BITS-1:0] entry_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PRIO_BITS-1:0]  out_priority;
	logic [VALUE_BITS-1:0] out_value;
	logic [1:0]            status;
	logic [CNT_BITS-1:0]   occupancy;

	bit                    hold_off_req = 1'b0;
	prio_queue_mirror      mirror = new();

	sorted_priority_queue_unit #(
		.DEPTH(DEPTH),
		.PRIO_BITS(PRIO_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.entry_priority(entry_priority),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_priority(out_priority),
		.out_value(out_value),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				mirror.check_result(out_priority, out_value, status, occupancy);
			if (in_valid && in_ready)
				mirror.note_request(command, entry_priority, entry_value);
		end
	end

	// End the run if nothing moves on either channel for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result side: rotate through stall patterns, hold off on request.
	initial begin
		int unsigned cyc;
		int          hold_left;
		cyc = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 256) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ((cyc % 4) == 0);
					default: out_ready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	task automatic send_request(input logic cmd, input logic [PRIO_BITS-1:0] p,
			input logic [VALUE_BITS-1:0] v);
		in_valid <= 1'b1;
		command <= cmd;
		entry_priority <= p;
		entry_value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending_results.size() != 0);
	endtask

	initial begin
		int                    sent;
		int                    burst;
		int                    enq_pct;
		int                    gap;
		bit                    drained_once;
		logic                  cmd;
		logic [PRIO_BITS-1:0]  p;
		logic [VALUE_BITS-1:0] v;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty dequeue, fill with extremes and ties, reject on full.
		send_request(spq_pkg::CMD_DEQ, '1, '1);
		send_request(spq_pkg::CMD_ENQ, 8'd255, 16'hffff);
		send_request(spq_pkg::CMD_ENQ, 8'd0, 16'h0000);
		send_request(spq_pkg::CMD_ENQ, 8'd128, 16'h0001);
		send_request(spq_pkg::CMD_ENQ, 8'd128, 16'h0002);
		send_request(spq_pkg::CMD_ENQ, 8'd0, 16'h8000);
		send_request(spq_pkg::CMD_ENQ, 8'd255, 16'h7fff);
		send_request(spq_pkg::CMD_ENQ, 8'd128, 16'h0003);
		for (int i = 0; i < 9; i++)
			send_request(spq_pkg::CMD_ENQ, PRIO_BITS'(i * 29), VALUE_BITS'(16'h5a5a ^ i));
		send_request(spq_pkg::CMD_ENQ, 8'd1, 16'hdead);
		for (int i = 0; i < 5; i++)
			send_request(spq_pkg::CMD_DEQ, '0, '0);
		wait_drained();

		sent = 0;
		drained_once = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			// vary the mix so the queue wanders between empty and full
			case ($urandom_range(0, 3))
				0: enq_pct = 15;
				1: enq_pct = 50;
				2: enq_pct = 85;
				default: enq_pct = 97;
			endcase
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				cmd = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
				case ($urandom_range(0, 3))
					0: p = PRIO_BITS'($urandom_range(0, 3));
					1: p = ($urandom_range(0, 1) == 1) ? '1 : '0;
					default: p = PRIO_BITS'($urandom_range(0, 255));
				endcase
				v = VALUE_BITS'($urandom_range(0, 65535));
				send_request(cmd, p, v);
				sent++;
				if (sent == 400 || sent == 1100)
					hold_off_req = 1'b1;
			end
			if (sent >= 800 && !drained_once) begin
				drained_once = 1'b1;
				wait_drained();
			end else if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				pause_sender(gap);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		mirror.close_out();
		if (mirror.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
